/* rtl/core/cbsp_pkg.sv */
// Shared types, constants and helpers of the cpio binary stream parser.
`default_nettype none

package cbsp_pkg;

    // Header layout and magic words
    localparam int HDR_BYTES   = 26;
    localparam int TRAILER_LEN = 11;
    localparam int REC_MAX     = 3;    // records one archive byte can cause
    localparam int QDEPTH      = 4;    // output queue entries

    localparam logic [7:0] MAGIC_HI = 8'hc7;
    localparam logic [7:0] MAGIC_LO = 8'h71;

    // Record kinds
    localparam logic [2:0] KIND_NAME   = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_BADMAG = 3'd4;

    // Parse phases, one-hot
    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_NAME     = 7'b0000010,
        PH_NAME_PAD = 7'b0000100,
        PH_DATA     = 7'b0001000,
        PH_DATA_PAD = 7'b0010000,
        PH_DONE     = 7'b0100000,
        PH_ERROR    = 7'b1000000
    } t_phase;

    // One result record
    typedef struct packed {
        logic [2:0]  rec_kind;
        logic        is_last;
        logic [7:0]  byte_value;
        logic [15:0] source_device;
        logic [15:0] inode_number;
        logic [15:0] mode_bits;
        logic [15:0] user_id;
        logic [15:0] group_id;
        logic [15:0] link_count;
        logic [15:0] link_device;
        logic [31:0] mod_time;
        logic [31:0] file_size;
    } t_rec;

    // Records produced by one accepted byte, in order
    typedef struct packed {
        t_rec [REC_MAX-1:0] recs;
        logic [1:0]         count;
    } t_push;

    // Header word from its two bytes; swapped means big-endian archive
    function automatic logic [15:0] hdr_word(input logic [7:0] b_even,
                                             input logic [7:0] b_odd,
                                             input logic       swapped);
        hdr_word = swapped ? {b_even, b_odd} : {b_odd, b_even};
    endfunction

    // Name of the end-of-archive entry, with its terminating zero
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        case (idx)
            4'd0:    trailer_char = 8'h54;  // T
            4'd1:    trailer_char = 8'h52;  // R
            4'd2:    trailer_char = 8'h41;  // A
            4'd3:    trailer_char = 8'h49;  // I
            4'd4:    trailer_char = 8'h4c;  // L
            4'd5:    trailer_char = 8'h45;  // E
            4'd6:    trailer_char = 8'h52;  // R
            4'd7:    trailer_char = 8'h21;  // !
            4'd8:    trailer_char = 8'h21;  // !
            4'd9:    trailer_char = 8'h21;  // !
            default: trailer_char = 8'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cbsp_parser.sv */
// Byte parser: header collection, name and data streaming, record generation.
`default_nettype none

module cbsp_parser
    import cbsp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,    // byte transfer this cycle
    input  wire logic [7:0] i_byte,
    input  wire logic       i_ends,
    output t_push           o_push
);

    // State
    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_count, n_byte_count;
    logic [7:0]  r_hdr [HDR_BYTES];
    logic [7:0]  m_hdr [HDR_BYTES];
    logic        r_swapped, n_swapped;
    logic [15:0] r_name_len, n_name_len;
    logic [31:0] r_remaining, n_remaining;
    logic        r_trailer, n_trailer;
    logic        r_padded, n_padded;

    // Record slots: streamed byte, header or end or bad magic, end flag
    t_rec rec_a, rec_b, rec_c;
    logic va, vb, vc;
    t_rec hdr_rec;
    logic [31:0] fsize;

    // Header store view with this byte written in
    always_comb begin
        logic [4:0] wa;
        wa = (r_byte_count >= 16'(HDR_BYTES)) ? 5'd0 : r_byte_count[4:0];
        for (int i = 0; i < HDR_BYTES; i++) begin
            m_hdr[i] = r_hdr[i];
        end
        if (r_phase == PH_HEADER) begin
            m_hdr[wa] = i_byte;
        end
    end

    // Header record from the store
    always_comb begin
        hdr_rec               = '0;
        hdr_rec.rec_kind      = KIND_HEADER;
        hdr_rec.source_device = hdr_word(m_hdr[2],  m_hdr[3],  r_swapped);
        hdr_rec.inode_number  = hdr_word(m_hdr[4],  m_hdr[5],  r_swapped);
        hdr_rec.mode_bits     = hdr_word(m_hdr[6],  m_hdr[7],  r_swapped);
        hdr_rec.user_id       = hdr_word(m_hdr[8],  m_hdr[9],  r_swapped);
        hdr_rec.group_id      = hdr_word(m_hdr[10], m_hdr[11], r_swapped);
        hdr_rec.link_count    = hdr_word(m_hdr[12], m_hdr[13], r_swapped);
        hdr_rec.link_device   = hdr_word(m_hdr[14], m_hdr[15], r_swapped);
        hdr_rec.mod_time      = {hdr_word(m_hdr[16], m_hdr[17], r_swapped),
                                 hdr_word(m_hdr[18], m_hdr[19], r_swapped)};
        fsize                 = {hdr_word(m_hdr[22], m_hdr[23], r_swapped),
                                 hdr_word(m_hdr[24], m_hdr[25], r_swapped)};
        hdr_rec.file_size     = fsize;
    end

    // Next state and records
    always_comb begin
        logic [15:0] cnt1;
        logic [15:0] nl;
        logic [15:0] fin_nl;
        logic        fin;
        logic        fin_tm;
        logic        tm;
        logic        done;
        logic [31:0] rem;

        cnt1   = '0;
        nl     = '0;
        fin_nl = r_name_len;
        fin    = 1'b0;
        fin_tm = r_trailer;
        tm     = r_trailer;
        done   = 1'b0;
        rem    = '0;

        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_swapped    = r_swapped;
        n_name_len   = r_name_len;
        n_remaining  = r_remaining;
        n_trailer    = r_trailer;
        n_padded     = r_padded;

        rec_a = '0;
        rec_b = '0;
        rec_c = '0;
        va    = 1'b0;
        vb    = 1'b0;
        vc    = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                cnt1 = ((r_byte_count >= 16'(HDR_BYTES)) ? 16'd0 : r_byte_count) + 16'd1;
                n_byte_count = cnt1;
                if (cnt1 == 16'd2 && m_hdr[0] == MAGIC_HI && m_hdr[1] == MAGIC_LO) begin
                    n_swapped = 1'b0;
                end else if (cnt1 == 16'd2 && m_hdr[0] == MAGIC_LO
                             && m_hdr[1] == MAGIC_HI) begin
                    n_swapped = 1'b1;
                end else if (cnt1 == 16'd2) begin
                    vb             = 1'b1;
                    rec_b.rec_kind = KIND_BADMAG;
                    n_phase        = PH_ERROR;
                end
                if (vb == 1'b0 && cnt1 == 16'(HDR_BYTES)) begin
                    nl           = hdr_word(m_hdr[20], m_hdr[21], r_swapped);
                    n_name_len   = nl;
                    n_byte_count = '0;
                    n_trailer    = 1'b1;
                    if (nl == 16'd0) begin
                        fin    = 1'b1;
                        fin_tm = 1'b1;
                        fin_nl = nl;
                    end else begin
                        n_phase = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                va               = 1'b1;
                rec_a.rec_kind   = KIND_NAME;
                rec_a.is_last    = ({1'b0, r_byte_count} + 17'd1) == {1'b0, r_name_len};
                rec_a.byte_value = i_byte;
                if (r_byte_count < 16'(TRAILER_LEN)
                    && i_byte != trailer_char(r_byte_count[3:0])) begin
                    tm = 1'b0;
                end
                n_trailer = tm;
                cnt1 = r_byte_count + 16'd1;
                n_byte_count = cnt1;
                if (cnt1 >= r_name_len) begin
                    if (r_name_len[0]) begin
                        n_phase = PH_NAME_PAD;
                    end else begin
                        fin    = 1'b1;
                        fin_tm = tm;
                    end
                end
            end
            PH_NAME_PAD: begin
                fin    = 1'b1;
                fin_tm = r_trailer;
            end
            PH_DATA: begin
                va               = 1'b1;
                rec_a.rec_kind   = KIND_DATA;
                rec_a.is_last    = (r_remaining <= 32'd1);
                rec_a.byte_value = i_byte;
                rem = r_remaining - {31'd0, (r_remaining != 32'd0)};
                n_remaining = rem;
                if (rem == 32'd0) begin
                    if (r_padded) begin
                        n_phase = PH_DATA_PAD;
                    end else begin
                        n_phase      = PH_HEADER;
                        n_byte_count = '0;
                    end
                end
            end
            PH_DATA_PAD: begin
                n_phase      = PH_HEADER;
                n_byte_count = '0;
            end
            PH_DONE: begin
                done = 1'b1;
            end
            default: begin
            end
        endcase

        // Name complete: end-of-archive entry or header record
        if (fin) begin
            vb = 1'b1;
            if (fin_tm && fin_nl >= 16'(TRAILER_LEN)) begin
                rec_b.rec_kind = KIND_END;
                n_phase        = PH_DONE;
            end else begin
                rec_b       = hdr_rec;
                n_remaining = fsize;
                n_padded    = fsize[0];
                if (fsize == 32'd0) begin
                    n_phase      = PH_HEADER;
                    n_byte_count = '0;
                end else begin
                    n_phase = PH_DATA;
                end
            end
        end

        // Source ends after this byte
        if (!done && i_ends && n_phase != PH_DONE) begin
            vc             = 1'b1;
            rec_c.rec_kind = KIND_END;
            n_phase        = PH_DONE;
        end
    end

    // Pack the records in order
    always_comb begin
        logic [1:0] k;
        k           = '0;
        o_push.recs = '0;
        if (va) begin
            o_push.recs[k] = rec_a;
            k = k + 2'd1;
        end
        if (vb) begin
            o_push.recs[k] = rec_b;
            k = k + 2'd1;
        end
        if (vc) begin
            o_push.recs[k] = rec_c;
            k = k + 2'd1;
        end
        o_push.count = i_accept ? k : 2'd0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_count <= '0;
            r_swapped    <= 1'b0;
            r_name_len   <= '0;
            r_remaining  <= '0;
            r_trailer    <= 1'b1;
            r_padded     <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_swapped    <= n_swapped;
            r_name_len   <= n_name_len;
            r_remaining  <= n_remaining;
            r_trailer    <= n_trailer;
            r_padded     <= n_padded;
        end
    end

    // Header store
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < HDR_BYTES; i++) begin
                r_hdr[i] <= m_hdr[i];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cbsp_out_queue.sv */
// Output record queue: takes up to three records a cycle, gives one a cycle while i_ready is high.
`default_nettype none

module cbsp_out_queue
    import cbsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,     // space for the records of one more byte
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_rec       o_rec
);

    t_rec       r_q [QDEPTH];
    t_rec       n_q [QDEPTH];
    logic [2:0] r_count, n_count;
    logic       r_room;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_rec   = r_q[0];
    assign o_room  = r_room;
    assign pop     = o_valid & i_ready;

    // Shift on pop, append after the remaining entries
    always_comb begin
        logic [2:0] base;
        base    = r_count - {2'd0, pop};
        n_count = base + {1'b0, i_push.count};
        for (int j = 0; j < QDEPTH; j++) begin
            if (pop && j < QDEPTH - 1) begin
                n_q[j] = r_q[j + 1];
            end else begin
                n_q[j] = r_q[j];
            end
            for (int i = 0; i < REC_MAX; i++) begin
                if (2'(i) < i_push.count && base + 3'(i) == 3'(j)) begin
                    n_q[j] = i_push.recs[i];
                end
            end
        end
    end

    // Fill level and input room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_room  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_room  <= (n_count <= 3'(QDEPTH - REC_MAX));
        end
    end

    // Entries
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QDEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cpio_binary_stream_parser.sv */
// Top level of the old-binary cpio archive stream parser.
//
// Input stream: one archive byte per transfer on s_axis; tlast marks that the
// source ends (or fails) after this byte and forces an end-of-archive record.
// Output stream: one record per transfer on m_axis; tuser carries the record
// kind (name byte, header, data byte, end, bad magic), tlast marks the last
// name byte or last data byte of an entry, tdata carries the byte and the
// header words. Fields that do not apply to a record kind read as zero.
// A byte's records enter the output queue at its transfer and leave on m_axis from the queue's head.
// Throughput: one byte per cycle while m_axis is ready and each byte yields at most one record;
// a byte that completes a name may yield up to three records, which drain
// through a four-entry output queue at one per cycle.
// s_axis_tready is high while the queue holds at most one record, so it drops
// when m_axis stalls or after a burst of records, and input waits.
// Reset (synchronous, active low) empties the queue, deasserts tready for
// the reset cycles and the first cycle after them, and returns the parser to
// awaiting a header.
// After the end record, or after bad magic, every further byte is taken and
// dropped; only the end flag still yields its end record after bad magic.
`default_nettype none

module cpio_binary_stream_parser
    import cbsp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Archive bytes
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data_byte
    input  wire logic         s_axis_tlast,   // input_ends
    // Records
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // byte_value, source_device, inode_number, mode_bits, user_id,
    // group_id, link_count, link_device, mod_time, file_size
    output logic [183:0]      m_axis_tdata,
    output logic [2:0]        m_axis_tuser,   // rec_kind
    output logic              m_axis_tlast    // is_last
);

    logic  in_xfer;
    logic  room;
    t_push push;
    t_rec  rec;

    assign s_axis_tready = room;
    assign in_xfer       = s_axis_tvalid & room;

    // Parser
    cbsp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_byte   (s_axis_tdata),
        .i_ends   (s_axis_tlast),
        .o_push   (push)
    );

    // Output queue
    cbsp_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_rec    (rec)
    );

    // Record fields onto the bus
    assign m_axis_tuser = rec.rec_kind;
    assign m_axis_tlast = rec.is_last;
    assign m_axis_tdata = {rec.file_size, rec.mod_time, rec.link_device,
                           rec.link_count, rec.group_id, rec.user_id,
                           rec.mode_bits, rec.inode_number, rec.source_device,
                           rec.byte_value};

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for the cpio binary stream parser: byte stimulus, record scoreboard.
`timescale 1ns / 100ps

module testbench;
    import cbsp_pkg::*;

    localparam int          IDLE_LIMIT  = 2000;   // cycles with no transfer at all
    localparam int          HOLD_CYCLES = 80;     // long receiver hold-off
    localparam logic [15:0] MAGIC_WORD  = {MAGIC_LO, MAGIC_HI};

    typedef enum int {NAME_RANDOM, NAME_NEAR, NAME_TRAILER} t_name_mode;

    // Expected-record store with its own copy of the parser state
    class record_scoreboard;
        t_rec        expected_recs[$];
        int          errors;
        t_phase      phase;
        logic [15:0] hcount;
        logic [7:0]  hstore[HDR_BYTES];
        logic        swapped;
        logic [15:0] nlen;
        logic [31:0] data_left;
        logic        tmatch;
        logic        dpad;

        function new();
            errors    = 0;
            phase     = PH_HEADER;
            hcount    = '0;
            foreach (hstore[i]) hstore[i] = 8'h00;
            swapped   = 1'b0;
            nlen      = '0;
            data_left = '0;
            tmatch    = 1'b1;
            dpad      = 1'b0;
        endfunction

        function int pending();
            return expected_recs.size();
        endfunction

        // End-of-archive entry name with its terminating zero
        function logic [7:0] trailer_byte(int idx);
            logic [87:0] text;
            text = {"TRAILER!!!", 8'h00};
            return text[87-8*idx -: 8];
        endfunction

        function logic [15:0] hword(int k);
            logic [7:0] even_b;
            logic [7:0] odd_b;
            even_b = hstore[(2*k) % HDR_BYTES];
            odd_b  = hstore[(2*k+1) % HDR_BYTES];
            return swapped ? {even_b, odd_b} : {odd_b, even_b};
        endfunction

        function void push_kind(logic [2:0] kind);
            t_rec r;
            r = '0;
            r.rec_kind = kind;
            expected_recs.push_back(r);
        endfunction

        // Name complete: header record or end of archive
        function void close_name();
            t_rec        r;
            logic [31:0] fsize;
            if (tmatch && nlen >= TRAILER_LEN) begin
                push_kind(KIND_END);
                phase = PH_DONE;
                return;
            end
            r = '0;
            r.rec_kind      = KIND_HEADER;
            r.source_device = hword(1);
            r.inode_number  = hword(2);
            r.mode_bits     = hword(3);
            r.user_id       = hword(4);
            r.group_id      = hword(5);
            r.link_count    = hword(6);
            r.link_device   = hword(7);
            r.mod_time      = {hword(8), hword(9)};
            fsize           = {hword(11), hword(12)};
            r.file_size     = fsize;
            expected_recs.push_back(r);
            data_left = fsize;
            dpad      = fsize[0];
            if (fsize == 32'd0) begin
                phase  = PH_HEADER;
                hcount = '0;
            end else begin
                phase = PH_DATA;
            end
        endfunction

        // One accepted archive byte: queue the records it causes
        function void note_byte(logic [7:0] b, logic ends);
            t_rec r;
            r = '0;
            case (phase)
                PH_HEADER: begin
                    if (hcount >= HDR_BYTES) hcount = '0;
                    hstore[hcount] = b;
                    hcount++;
                    if (hcount == 16'd2) begin
                        if (hstore[0] == MAGIC_HI && hstore[1] == MAGIC_LO) begin
                            swapped = 1'b0;
                        end else if (hstore[0] == MAGIC_LO && hstore[1] == MAGIC_HI) begin
                            swapped = 1'b1;
                        end else begin
                            push_kind(KIND_BADMAG);
                            phase = PH_ERROR;
                        end
                    end
                    if (phase == PH_HEADER && hcount == HDR_BYTES) begin
                        nlen   = hword(10);
                        hcount = '0;
                        tmatch = 1'b1;
                        if (nlen == 16'd0) close_name();
                        else phase = PH_NAME;
                    end
                end
                PH_NAME: begin
                    r.rec_kind   = KIND_NAME;
                    r.is_last    = ({1'b0, hcount} + 17'd1 == {1'b0, nlen});
                    r.byte_value = b;
                    expected_recs.push_back(r);
                    if (hcount < TRAILER_LEN && b != trailer_byte(int'(hcount))) tmatch = 1'b0;
                    hcount++;
                    if (hcount >= nlen) begin
                        if (nlen[0]) phase = PH_NAME_PAD;
                        else close_name();
                    end
                end
                PH_NAME_PAD: close_name();
                PH_DATA: begin
                    r.rec_kind   = KIND_DATA;
                    r.is_last    = (data_left <= 32'd1);
                    r.byte_value = b;
                    expected_recs.push_back(r);
                    if (data_left > 32'd0) data_left--;
                    if (data_left == 32'd0) begin
                        if (dpad) begin
                            phase = PH_DATA_PAD;
                        end else begin
                            phase  = PH_HEADER;
                            hcount = '0;
                        end
                    end
                end
                PH_DATA_PAD: begin
                    phase  = PH_HEADER;
                    hcount = '0;
                end
                PH_DONE: return;
                default: ;
            endcase
            // End flag closes the archive after this byte's records
            if (ends && phase != PH_DONE) begin
                push_kind(KIND_END);
                phase = PH_DONE;
            end
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        endtask

        task cmp_field(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        // One accepted record against the oldest expectation
        task check_record(t_rec got);
            t_rec want;
            if (expected_recs.size() == 0) begin
                report_mismatch("record with none expected, kind", 32'(got.rec_kind), 32'd0);
                return;
            end
            want = expected_recs.pop_front();
            cmp_field("rec_kind", 32'(got.rec_kind), 32'(want.rec_kind));
            cmp_field("is_last", 32'(got.is_last), 32'(want.is_last));
            cmp_field("byte_value", 32'(got.byte_value), 32'(want.byte_value));
            cmp_field("source_device", 32'(got.source_device), 32'(want.source_device));
            cmp_field("inode_number", 32'(got.inode_number), 32'(want.inode_number));
            cmp_field("mode_bits", 32'(got.mode_bits), 32'(want.mode_bits));
            cmp_field("user_id", 32'(got.user_id), 32'(want.user_id));
            cmp_field("group_id", 32'(got.group_id), 32'(want.group_id));
            cmp_field("link_count", 32'(got.link_count), 32'(want.link_count));
            cmp_field("link_device", 32'(got.link_device), 32'(want.link_device));
            cmp_field("mod_time", got.mod_time, want.mod_time);
            cmp_field("file_size", got.file_size, want.file_size);
        endtask
    endclass

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [183:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    record_scoreboard sb = new();
    t_rec             mon_rec;
    int               bytes_sent = 0;
    bit               calm       = 1'b0;
    int               entry_pos  = 0;
    int               cut_at     = -1;
    int               idle_cycles = 0;

    cpio_binary_stream_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Monitor both streams at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                mon_rec.rec_kind      = m_axis_tuser;
                mon_rec.is_last       = m_axis_tlast;
                mon_rec.byte_value    = m_axis_tdata[7:0];
                mon_rec.source_device = m_axis_tdata[23:8];
                mon_rec.inode_number  = m_axis_tdata[39:24];
                mon_rec.mode_bits     = m_axis_tdata[55:40];
                mon_rec.user_id       = m_axis_tdata[71:56];
                mon_rec.group_id      = m_axis_tdata[87:72];
                mon_rec.link_count    = m_axis_tdata[103:88];
                mon_rec.link_device   = m_axis_tdata[119:104];
                mon_rec.mod_time      = m_axis_tdata[151:120];
                mon_rec.file_size     = m_axis_tdata[183:152];
                sb.check_record(mon_rec);
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Record receiver: random stalls, one long hold-off
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && bytes_sent >= 220) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 9);
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge i_clk);
        end
    end

    // One byte transfer, with an optional gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic ends);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= ends;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Entry byte; the cut position carries the end flag and drops the rest
    task automatic put_byte(input logic [7:0] b);
        if (cut_at >= 0 && entry_pos > cut_at) return;
        send_byte(b, entry_pos == cut_at);
        entry_pos++;
    endtask

    task automatic put_word(input logic [15:0] w, input bit big);
        put_byte(big ? w[15:8] : w[7:0]);
        put_byte(big ? w[7:0] : w[15:8]);
    endtask

    // Whole archive entry: header, name, pad, data, pad
    task automatic send_entry(input bit big, input int fill, input logic [15:0] nlen,
                              input logic [31:0] fsize, input t_name_mode mode,
                              input int cut);
        logic [15:0]     w;
        logic [7:0]      b;
        int              mut;
        longint unsigned n;
        entry_pos = 0;
        cut_at    = cut;
        put_word(MAGIC_WORD, big);
        for (int k = 1; k <= 12; k++) begin
            if (k == 10) w = nlen;
            else if (k == 11) w = fsize[31:16];
            else if (k == 12) w = fsize[15:0];
            else if (fill < 0) w = 16'($urandom);
            else w = fill[15:0];
            put_word(w, big);
        end
        mut = (nlen > 0) ? $urandom_range(0, (nlen < 11 ? int'(nlen) : 11) - 1) : 0;
        for (int i = 0; i < int'(nlen); i++) begin
            b = 8'($urandom);
            if (mode != NAME_RANDOM && i < 11) begin
                b = sb.trailer_byte(i);
                if (mode == NAME_NEAR && i == mut) b = b ^ 8'($urandom_range(1, 255));
            end
            put_byte(b);
        end
        if (nlen[0]) put_byte(8'($urandom));
        n = 0;
        while (n < longint'(fsize) && !(cut >= 0 && entry_pos > cut)) begin
            put_byte(8'($urandom));
            n++;
        end
        if (fsize[0]) put_byte(8'($urandom));
    endtask

    // Stop offering until every expected record has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    // Main sequence
    initial begin
        logic [15:0] nlen;
        logic [31:0] fsize;
        logic [7:0]  b0;
        logic [7:0]  b1;
        int          pick;
        int          extra;
        t_name_mode  mode;
        bit          drained_once;
        drained_once = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty name and data, all-ones words, odd pads, near-trailer names
        send_entry(1'b0, 0, 16'd0, 32'd0, NAME_RANDOM, -1);
        send_entry(1'b1, 16'hffff, 16'd1, 32'd1, NAME_RANDOM, -1);
        send_entry(1'b0, -1, 16'd10, 32'd2, NAME_TRAILER, -1);
        send_entry(1'b1, -1, 16'd11, 32'd3, NAME_NEAR, -1);
        send_entry(1'b0, -1, 16'd2, 32'd0, NAME_RANDOM, -1);

        // Random well-formed entries with random content
        while (bytes_sent < 420) begin
            pick = $urandom_range(0, 9);
            nlen = (pick < 8) ? 16'($urandom_range(0, 14)) : 16'($urandom_range(15, 40));
            pick = $urandom_range(0, 9);
            if (pick == 0) fsize = 32'd0;
            else if (pick < 8) fsize = 32'($urandom_range(1, 24));
            else fsize = 32'($urandom_range(25, 60));
            mode = (nlen > 0 && $urandom_range(0, 6) == 0) ? NAME_NEAR : NAME_RANDOM;
            pick = $urandom_range(0, 9);
            send_entry(1'($urandom), (pick == 0) ? 0 : (pick == 1) ? 16'hffff : -1,
                       nlen, fsize, mode, -1);
            if (!drained_once && bytes_sent >= 320) begin
                drained_once = 1'b1;
                wait_drained();
            end
            if (bytes_sent >= 390) calm = 1'b1;
        end

        // Closing: trailer entry, bad magic, or end flag in mid entry
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            send_entry(1'($urandom), -1, 16'($urandom_range(11, 14)),
                       32'($urandom_range(0, 5)), NAME_TRAILER, -1);
        end else if (pick == 1) begin
            b0 = 8'($urandom);
            b1 = 8'($urandom);
            if ((b0 == MAGIC_HI && b1 == MAGIC_LO) || (b0 == MAGIC_LO && b1 == MAGIC_HI))
                b1 = b1 ^ 8'h01;
            extra = $urandom_range(0, 6);
            send_byte(b0, 1'b0);
            send_byte(b1, extra == 0);
            for (int i = 1; i <= extra; i++) send_byte(8'($urandom), i == extra);
        end else begin
            nlen = 16'($urandom_range(0, 14));
            send_entry(1'($urandom), -1, nlen, {1'b1, 31'($urandom)}, NAME_RANDOM,
                       $urandom_range(0, 26 + int'(nlen) + int'(nlen[0]) + 8));
        end

        // Bytes after the archive has closed are taken and dropped
        for (int i = 0; i < 8; i++) send_byte(8'($urandom), (i == 7) ? 1'b1 : 1'($urandom));

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
